[rtl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared types, codes and default sizes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned CapacityDef   = 32;
  localparam int unsigned KeyBitsDef    = 10;
  localparam int unsigned HandleBitsDef = 16;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_DUMP   = 2'd3
  } skt_op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } skt_status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } skt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;      // latch the request and register the compares
    logic        commit;       // apply the insert or delete shift to the store
    logic        push;         // load a result into the output register
    logic        push_entry;   // the pushed result carries the entry at the index
    skt_status_e push_status;  // status code of the pushed result
    logic        idx_load;     // load the scan index with its start value
    logic        idx_advance;  // step the scan index
  } skt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    skt_op_e op;         // operation of the request in work
    logic    full;       // table holds CAPACITY entries
    logic    found;      // at least one held entry matches the request key
    logic    empty;      // table holds no entry
    logic    emit_last;  // the entry at the scan index is the final one to emit
    logic    out_free;   // the output register can take a result this cycle
  } skt_sts_t;

endpackage

[rtl/sorted_key_table_top.sv]
// ----------------------------------------------------------------------------
// Sorted key table
// Keeps up to CAPACITY key and handle pairs in ascending key order.
// ----------------------------------------------------------------------------
// One request is in work at a time. A request is taken in the cycle that the
// table is idle; its key is compared against every held slot at once and the
// compare results are registered. Insert and delete then shift the slot row
// in the execute state, unless the table is full or no key matches; each gives
// one result. A find gives one result per matching entry (one not-found result
// when nothing matches) and a dump one result per held entry (one result for an
// empty table); the result register passes one entry each cycle unless the
// result side stalls. No clearing pass follows reset.
module sorted_key_table_top #(
  parameter int unsigned CAPACITY    = skt_pkg::CapacityDef,
  parameter int unsigned KEY_BITS    = skt_pkg::KeyBitsDef,
  parameter int unsigned HANDLE_BITS = skt_pkg::HandleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic [KEY_BITS-1:0]              key_i,
  input  logic [HANDLE_BITS-1:0]           record_handle_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic                             entry_valid_o,
  output logic [KEY_BITS-1:0]              entry_key_o,
  output logic [HANDLE_BITS-1:0]           entry_handle_o,
  output logic                             last_o,
  output logic [$clog2(CAPACITY + 1)-1:0]  entry_count_o
);
  import skt_pkg::*;

  skt_cmd_t cmd;
  skt_sts_t sts;

  // Request sequencing.
  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry store, compare, shift and result register.
  skt_dpath #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .CNT_W       ($clog2(CAPACITY + 1))
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .record_handle_i (record_handle_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_valid_o   (entry_valid_o),
    .entry_key_o     (entry_key_o),
    .entry_handle_o  (entry_handle_o),
    .last_o          (last_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

[rtl/skt_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences one request at a time: capture, execute, then entry emission for finds and dumps.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skt_pkg::skt_sts_t sts_i,
  output skt_pkg::skt_cmd_t cmd_o
);
  import skt_pkg::*;

  skt_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_FIND: begin
            if (sts_i.found) begin
              state_d = S_EMIT;
            end else if (sts_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          OP_DUMP: begin
            if (!sts_i.empty) begin
              state_d = S_EMIT;
            end else if (sts_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o             = '0;
    cmd_o.push_status = ST_DONE;
    in_stall_o        = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            cmd_o.push        = sts_i.out_free;
            cmd_o.commit      = sts_i.out_free && !sts_i.full;
            cmd_o.push_status = sts_i.full ? ST_FULL : ST_DONE;
          end
          OP_DELETE: begin
            cmd_o.push        = sts_i.out_free;
            cmd_o.commit      = sts_i.out_free && sts_i.found;
            cmd_o.push_status = sts_i.found ? ST_DONE : ST_NOT_FOUND;
          end
          OP_FIND: begin
            cmd_o.idx_load    = sts_i.found;
            cmd_o.push        = !sts_i.found && sts_i.out_free;
            cmd_o.push_status = ST_NOT_FOUND;
          end
          OP_DUMP: begin
            cmd_o.idx_load = !sts_i.empty;
            cmd_o.push     = sts_i.empty && sts_i.out_free;
          end
          default: ;
        endcase
      end
      S_EMIT: begin
        cmd_o.push        = sts_i.out_free;
        cmd_o.push_entry  = 1'b1;
        cmd_o.idx_advance = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/skt_dpath.sv]
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Entry store with parallel compare and shift, scan index and result register.
// ----------------------------------------------------------------------------
module skt_dpath #(
  parameter int unsigned CAPACITY    = skt_pkg::CapacityDef,
  parameter int unsigned KEY_BITS    = skt_pkg::KeyBitsDef,
  parameter int unsigned HANDLE_BITS = skt_pkg::HandleBitsDef,
  parameter int unsigned CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  skt_pkg::skt_cmd_t      cmd_i,
  output skt_pkg::skt_sts_t      sts_o,
  input  logic [1:0]             opcode_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [HANDLE_BITS-1:0] record_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic                   entry_valid_o,
  output logic [KEY_BITS-1:0]    entry_key_o,
  output logic [HANDLE_BITS-1:0] entry_handle_o,
  output logic                   last_o,
  output logic [CNT_W-1:0]       entry_count_o
);
  import skt_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // Entry store, one register per slot, kept in ascending key order.
  logic [KEY_BITS-1:0]    ent_key_q [CAPACITY];
  logic [KEY_BITS-1:0]    ent_key_d [CAPACITY];
  logic [HANDLE_BITS-1:0] ent_hdl_q [CAPACITY];
  logic [HANDLE_BITS-1:0] ent_hdl_d [CAPACITY];
  logic [CNT_W-1:0]       count_q, count_d;

  // Request in work and its registered compare vectors.
  skt_op_e                op_q;
  logic [KEY_BITS-1:0]    req_key_q;
  logic [HANDLE_BITS-1:0] req_hdl_q;
  logic [CAPACITY-1:0]    lt_d, lt_q;
  logic [CAPACITY-1:0]    eq_d, eq_q;
  logic [CAPACITY-1:0]    at_pos;

  // Scan index for find and dump.
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] first_eq;
  logic [IDX_W:0]   idx_nxt;
  logic             emit_last;

  // Result register.
  logic                   out_valid_q;
  skt_status_e            out_status_q;
  logic                   out_ev_q;
  logic [KEY_BITS-1:0]    out_key_q;
  logic [HANDLE_BITS-1:0] out_hdl_q;
  logic                   out_last_q;
  logic [CNT_W-1:0]       out_cnt_q;
  logic                   out_free;

  // The slot where a new key belongs is the first one whose key is not smaller.
  assign at_pos = ~lt_q & {lt_q[CAPACITY-2:0], 1'b1};

  // Per-slot compare against the request key and per-slot shift.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic [KEY_BITS-1:0]    prv_key, nxt_key;
    logic [HANDLE_BITS-1:0] prv_hdl, nxt_hdl;

    if (g == 0) begin : g_first
      assign prv_key = req_key_q;
      assign prv_hdl = req_hdl_q;
    end else begin : g_rest
      assign prv_key = ent_key_q[g-1];
      assign prv_hdl = ent_hdl_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign nxt_key = ent_key_q[g];
      assign nxt_hdl = ent_hdl_q[g];
    end else begin : g_below
      assign nxt_key = ent_key_q[g+1];
      assign nxt_hdl = ent_hdl_q[g+1];
    end

    assign lt_d[g] = (CNT_W'(g) < count_q) && (ent_key_q[g] < key_i);
    assign eq_d[g] = (CNT_W'(g) < count_q) && (ent_key_q[g] == key_i);

    // Insert opens a gap at the insertion slot; delete closes it at the match.
    always_comb begin
      ent_key_d[g] = ent_key_q[g];
      ent_hdl_d[g] = ent_hdl_q[g];
      if (!lt_q[g]) begin
        if (op_q == OP_INSERT) begin
          ent_key_d[g] = at_pos[g] ? req_key_q : prv_key;
          ent_hdl_d[g] = at_pos[g] ? req_hdl_q : prv_hdl;
        end else begin
          ent_key_d[g] = nxt_key;
          ent_hdl_d[g] = nxt_hdl;
        end
      end
    end
  end

  // Store update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ent_key_q <= ent_key_d;
      ent_hdl_q <= ent_hdl_d;
    end
  end

  // Entry count after the operation.
  always_comb begin
    count_d = count_q;
    if (cmd_i.commit) begin
      count_d = (op_q == OP_INSERT) ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Request capture with the registered compare vectors.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= skt_op_e'(opcode_i);
      req_key_q <= key_i;
      req_hdl_q <= record_handle_i;
      lt_q      <= lt_d;
      eq_q      <= eq_d;
    end
  end

  // Matches are contiguous in a sorted table, so a find starts at the first one.
  always_comb begin
    first_eq = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq_q[i]) begin
        first_eq = IDX_W'(i);
      end
    end
  end

  // Scan index.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = (op_q == OP_FIND) ? first_eq : '0;
    end else if (cmd_i.idx_advance) begin
      idx_d = idx_nxt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // The final emitted entry: end of table for dump, end of the match run for find.
  assign idx_nxt = {1'b0, idx_q} + (IDX_W+1)'(1);

  always_comb begin
    if (op_q == OP_DUMP) begin
      emit_last = (idx_nxt == (IDX_W+1)'(count_q));
    end else if (idx_nxt == (IDX_W+1)'(CAPACITY)) begin
      emit_last = 1'b1;
    end else begin
      emit_last = !eq_q[idx_nxt[IDX_W-1:0]];
    end
  end

  // Result register; it takes a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_i.push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && out_free) begin
      out_status_q <= cmd_i.push_status;
      out_ev_q     <= cmd_i.push_entry;
      out_key_q    <= cmd_i.push_entry ? ent_key_q[idx_q] : '0;
      out_hdl_q    <= cmd_i.push_entry ? ent_hdl_q[idx_q] : '0;
      out_last_q   <= cmd_i.push_entry ? emit_last : 1'b1;
      out_cnt_q    <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entry_valid_o  = out_ev_q;
  assign entry_key_o    = out_key_q;
  assign entry_handle_o = out_hdl_q;
  assign last_o         = out_last_q;
  assign entry_count_o  = out_cnt_q;

  // Status to the controller.
  always_comb begin
    sts_o.op        = op_q;
    sts_o.full      = (count_q == CNT_W'(CAPACITY));
    sts_o.found     = |eq_q;
    sts_o.empty     = (count_q == '0);
    sts_o.emit_last = emit_last;
    sts_o.out_free  = out_free;
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An insert is applied only when a slot is free.
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (op_q == OP_INSERT) |-> count_q < CNT_W'(CAPACITY))
    else $error("insert applied to a full table");

  // A delete is applied only when a matching entry was seen.
  a_delete_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (op_q == OP_DELETE) |-> |eq_q)
    else $error("delete applied without a matching entry");

  // Emitted entries always come from held slots.
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && cmd_i.push_entry |-> {1'b0, idx_q} < (IDX_W+1)'(count_q))
    else $error("entry emitted from an empty slot");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives insert, delete, find and dump requests into the table, keeps its
// own sorted copy of the table contents, and checks every result field by
// field in order. The run covers directed edge cases, random traffic under
// three sender and receiver idling mixes, a long result-side hold-off, and
// a flood of inserts that fills the table and overflows it.
// ----------------------------------------------------------------------------
module tb;
  import skt_pkg::*;

  localparam int unsigned CAP   = CapacityDef;
  localparam int unsigned KEY_W = KeyBitsDef;
  localparam int unsigned HDL_W = HandleBitsDef;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct {
    skt_op_e           op;
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
  } table_req_t;

  typedef struct {
    skt_status_e       status;
    logic              entry_valid;
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
    logic              last;
    logic [CNT_W-1:0]  count;
  } table_res_t;

  // Clock, reset and DUT-facing signals; the ones the bench drives are known from time zero.
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [1:0]        opcode          = OP_INSERT;
  logic [KEY_W-1:0]  key             = '0;
  logic [HDL_W-1:0]  record_handle   = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [1:0]        status;
  logic              entry_valid;
  logic [KEY_W-1:0]  entry_key;
  logic [HDL_W-1:0]  entry_handle;
  logic              last;
  logic [CNT_W-1:0]  entry_count;

  // Request source and expected results.
  table_req_t        request_q[$];
  table_res_t        due_results[$];
  table_req_t        offered_req;
  logic              offer_next;

  // Shadow copy of the table contents.
  logic [KEY_W-1:0]  shadow_key[CAP];
  logic [HDL_W-1:0]  shadow_handle[CAP];
  int unsigned       shadow_count = 0;

  // Traffic shaping.
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  logic              hold_start     = 1'b0;
  int unsigned       hold_left      = 0;
  logic [KEY_W-1:0]  hot_keys[8];

  // Bookkeeping.
  int unsigned       cycle_cnt   = 0;
  int unsigned       err_count   = 0;
  int unsigned       n_requests  = 0;
  int unsigned       n_results   = 0;
  int unsigned       n_entries   = 0;
  int unsigned       n_missing   = 0;
  int unsigned       n_full      = 0;

  sorted_key_table_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .key_i           (key),
    .record_handle_i (record_handle),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .entry_valid_o   (entry_valid),
    .entry_key_o     (entry_key),
    .entry_handle_o  (entry_handle),
    .last_o          (last),
    .entry_count_o   (entry_count)
  );

  always #4 clk_i = ~clk_i;

  // Queue one expected result; the count is the table size after the request.
  function automatic void expect_result(skt_status_e st, logic ev, logic [KEY_W-1:0] k,
                                        logic [HDL_W-1:0] h, logic lst);
    table_res_t res;
    res.status      = st;
    res.entry_valid = ev;
    res.key         = k;
    res.handle      = h;
    res.last        = lst;
    res.count       = CNT_W'(shadow_count);
    due_results.push_back(res);
  endfunction

  // Apply one request to the shadow table and queue the results it causes.
  function automatic void apply_table_op(table_req_t rq);
    int unsigned pos;
    int unsigned hits;
    int unsigned seen;
    pos = 0;
    hits = 0;
    seen = 0;
    case (rq.op)
      OP_INSERT: begin
        if (shadow_count >= CAP) begin
          expect_result(ST_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          // Equal keys land ahead of the ones already held.
          while (pos < shadow_count && shadow_key[pos] < rq.key) pos++;
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_key[i]    = shadow_key[i-1];
            shadow_handle[i] = shadow_handle[i-1];
          end
          shadow_key[pos]    = rq.key;
          shadow_handle[pos] = rq.handle;
          shadow_count++;
          expect_result(ST_DONE, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        while (pos < shadow_count && shadow_key[pos] < rq.key) pos++;
        if (pos < shadow_count && shadow_key[pos] == rq.key) begin
          for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_key[i]    = shadow_key[i+1];
            shadow_handle[i] = shadow_handle[i+1];
          end
          shadow_count--;
          expect_result(ST_DONE, 1'b0, '0, '0, 1'b1);
        end else begin
          expect_result(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < shadow_count; i++)
          if (shadow_key[i] == rq.key) hits++;
        if (hits == 0) begin
          expect_result(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            if (shadow_key[i] == rq.key) begin
              seen++;
              expect_result(ST_DONE, 1'b1, shadow_key[i], shadow_handle[i], seen == hits);
            end
          end
        end
      end
      default: begin
        if (shadow_count == 0) begin
          expect_result(ST_DONE, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++)
            expect_result(ST_DONE, 1'b1, shadow_key[i], shadow_handle[i],
                          i + 1 == shadow_count);
        end
      end
    endcase
  endfunction

  // Print one mismatch and count it.
  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_req(skt_op_e op, logic [KEY_W-1:0] k, logic [HDL_W-1:0] h);
    table_req_t rq;
    rq.op     = op;
    rq.key    = k;
    rq.handle = h;
    request_q.push_back(rq);
  endtask

  // Random requests; half the keys come from a small set so that finds and
  // deletes hit held entries.
  task automatic add_random(int unsigned count, int unsigned ins_pct,
                            int unsigned del_pct, int unsigned find_pct);
    int unsigned roll;
    skt_op_e     op;
    logic [KEY_W-1:0] k;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + del_pct) op = OP_DELETE;
      else if (roll < ins_pct + del_pct + find_pct) op = OP_FIND;
      else op = OP_DUMP;
      if ($urandom_range(0, 1) == 1) k = hot_keys[$urandom_range(0, 7)];
      else k = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
      add_req(op, k, HDL_W'($urandom_range(0, (1 << HDL_W) - 1)));
    end
  endtask

  // Sender pause: wait until every request is taken and every result is back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // Request driver: predict on acceptance, then offer the next request or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      offer_next = in_valid;
      if (in_valid && !in_stall) begin
        apply_table_op(offered_req);
        n_requests++;
        offer_next = 1'b0;
      end
      if (!offer_next && request_q.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        offered_req   = request_q.pop_front();
        offer_next    = 1'b1;
        opcode        <= offered_req.op;
        key           <= offered_req.key;
        record_handle <= offered_req.handle;
      end
      in_valid <= offer_next;
    end
  end

  // Long result-side hold-off, counted on its own.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      hold_left <= HOLD_LEN;
    end
  end

  // Result monitor: random stall plus the hold-off, and in-order checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (entry_valid) n_entries++;
        if (status == ST_NOT_FOUND) n_missing++;
        if (status == ST_FULL) n_full++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected, key", entry_key, 0);
        end else begin
          if (status != due_results[0].status)
            report_mismatch("status", status, due_results[0].status);
          if (entry_valid != due_results[0].entry_valid)
            report_mismatch("entry_valid", entry_valid, due_results[0].entry_valid);
          if (entry_key != due_results[0].key)
            report_mismatch("entry_key", entry_key, due_results[0].key);
          if (entry_handle != due_results[0].handle)
            report_mismatch("entry_handle", entry_handle, due_results[0].handle);
          if (last != due_results[0].last)
            report_mismatch("last", last, due_results[0].last);
          if (entry_count != due_results[0].count)
            report_mismatch("entry_count", entry_count, due_results[0].count);
          void'(due_results.pop_front());
        end
      end
      out_stall <= (hold_left != 0) || hold_start ||
                   ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int i = 2; i < 8; i++) hot_keys[i] = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender mostly busy, receiver stalls often.
    @(negedge clk_i);
    send_idle_pct  = 13;
    recv_stall_pct = 46;

    // Directed: empty table, key extremes, equal keys and misses.
    add_req(OP_DUMP,   10'd0,    16'h0000);
    add_req(OP_FIND,   10'd0,    16'hffff);
    add_req(OP_DELETE, 10'd0,    16'h0000);
    add_req(OP_INSERT, 10'd0,    16'h0000);
    add_req(OP_INSERT, 10'd1023, 16'hffff);
    add_req(OP_INSERT, 10'd500,  16'haaaa);
    add_req(OP_INSERT, 10'd500,  16'h5555);
    add_req(OP_INSERT, 10'd500,  16'h1234);
    add_req(OP_FIND,   10'd500,  16'h0000);
    add_req(OP_FIND,   10'd1023, 16'h0000);
    add_req(OP_FIND,   10'd0,    16'h0000);
    add_req(OP_FIND,   10'd501,  16'h0000);
    add_req(OP_DELETE, 10'd500,  16'h0000);
    add_req(OP_FIND,   10'd500,  16'h0000);
    add_req(OP_DELETE, 10'd1023, 16'h0000);
    add_req(OP_DELETE, 10'd1023, 16'h0000);
    add_req(OP_DUMP,   10'd0,    16'h0000);
    add_req(OP_DELETE, 10'd0,    16'h0000);
    add_req(OP_INSERT, 10'd1023, 16'hffff);
    add_req(OP_DUMP,   10'd1023, 16'hffff);
    add_random(80, 45, 20, 20);
    wait_drained();

    // Sender idles often, receiver rarely; a long hold-off while inserts
    // flood in fills the table and runs it past capacity.
    send_idle_pct  = 46;
    recv_stall_pct = 13;
    hold_start <= 1'b1;
    add_random(38, 100, 0, 0);
    add_req(OP_DUMP, 10'd0, 16'h0000);
    add_req(OP_FIND, hot_keys[0], 16'h0000);
    add_req(OP_FIND, hot_keys[1], 16'h0000);
    add_req(OP_INSERT, hot_keys[2], 16'hffff);
    @(negedge clk_i);
    hold_start <= 1'b0;
    add_random(60, 35, 30, 20);
    wait_drained();

    // No idling on either side; deletes dominate to drain the table.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(80, 20, 50, 15);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", 0, due_results.size());
    $display("Ran %0d requests and checked %0d results in %0d cycles.",
             n_requests, n_results, cycle_cnt);
    $display("Results held %0d entries, %0d not-found and %0d table-full statuses.",
             n_entries, n_missing, n_full);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
